// ===== src/cbps_pkg.sv =====
// Shared constants and types for the credit based path selector.
package cbps_pkg;

    localparam int MAX_PATHS   = 16;
    localparam int CREDIT_BITS = 32;

    localparam int PATH_W     = $clog2(MAX_PATHS);
    localparam int CNT_W      = $clog2(MAX_PATHS + 1);
    localparam int LEN_W      = 16;
    localparam int QUANT_W    = 16;
    localparam int PCOUNT_W   = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [CREDIT_BITS-1:0] credit_t;
    typedef logic [CREDIT_BITS-1:0]        rounds_t;

    localparam credit_t CREDIT_MAX = {1'b0, {(CREDIT_BITS-1){1'b1}}};
    localparam credit_t CREDIT_MIN = {1'b1, {(CREDIT_BITS-1){1'b0}}};

    localparam logic [MODE_W-1:0] MODE_RR       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRR      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RR_ALIAS = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_COUNT = 2'd2;

    localparam logic [MODE_W-1:0]   RST_MODE       = MODE_DRR;
    localparam logic [QUANT_W-1:0]  RST_QUANTUM    = 16'd1500;
    localparam logic [PCOUNT_W-1:0] RST_PATH_COUNT = 5'd16;

endpackage

// ===== src/cbps_div.sv =====
// Restoring divider that finds the refill round count, one quotient bit per cycle.
module cbps_div
    import cbps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  rounds_t            dividend,
    input  logic [QUANT_W-1:0] divisor,
    output logic               done,
    output rounds_t            quotient
);

    localparam int STEP_W = $clog2(CREDIT_BITS + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    rounds_t            acc_reg;
    logic [QUANT_W-1:0] rem_reg;

    logic [QUANT_W:0]   trial;
    logic               fits;
    logic [QUANT_W:0]   diff;

    always_comb begin
        trial = {rem_reg, acc_reg[CREDIT_BITS-1]};
        fits  = trial >= {1'b0, divisor};
        diff  = trial - {1'b0, divisor};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(CREDIT_BITS);
            end else if (busy_reg) begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[QUANT_W-1:0] : trial[QUANT_W-1:0];
            acc_reg <= {acc_reg[CREDIT_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

// ===== src/credit_based_path_selector.sv =====
// Top level of the credit based path selector with its credit memory and sequencer.
//
// Usage: each transfer on the s_ channel carries a packet length; the block
// answers with exactly one transfer on the m_ channel that carries the path
// chosen for that packet. Configuration (mode, quantum, path count) is
// written on the cfg_ channel, which is always ready; the user must write it
// only while the block is idle, as the block does not enforce this. Modes 0
// and 3 answer from the round-robin cursor. Modes 1 and 2 scan the credit
// memory one entry per cycle through its single read port. When a refill is
// needed, the round count comes from the divider (or is one round when a DRR
// scan finds positive credit only below the cursor), followed by a second
// read-modify-write sweep of the credit memory. One item is in work at a
// time; s_ready is high only between items. A finished result sits in the
// output register while the next item is accepted; if the receiver stalls,
// the following result waits until the register is free. Reset restores the
// register defaults, zeroes the cursor and marks all credits as zero through
// per-entry valid bits, so the block is ready in the first cycle after reset.
module credit_based_path_selector
    import cbps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [LEN_W-1:0]      s_packet_length,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PATH_W-1:0]     m_path,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PROD_W = CREDIT_BITS + QUANT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int DIFF_W = CREDIT_BITS + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W-CREDIT_BITS+1){1'b0}}, {(CREDIT_BITS-1){1'b1}}};
    localparam logic signed [DIFF_W-1:0] DIFF_MIN = {2'b11, {(CREDIT_BITS-1){1'b0}}};

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SCAN   = 9'b000000010,
        ST_DECIDE = 9'b000000100,
        ST_DIV    = 9'b000001000,
        ST_MUL    = 9'b000010000,
        ST_REFILL = 9'b000100000,
        ST_PICK   = 9'b001000000,
        ST_CHARGE = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [MODE_W-1:0]   mode_reg;
    logic [QUANT_W-1:0]  quantum_reg;
    logic [PCOUNT_W-1:0] pcount_reg;
    logic [PATH_W-1:0]   cursor_reg;

    logic [CNT_W-1:0]    n_eff;
    logic [QUANT_W-1:0]  q_eff;
    logic [PATH_W-1:0]   c_eff;

    credit_t             credit_mem [MAX_PATHS];
    logic [MAX_PATHS-1:0] entry_vld_reg;
    credit_t             rd_data_reg;
    logic                rd_vld_reg;

    logic [CNT_W-1:0]    issue_idx_reg;
    logic                eval_valid_reg;
    logic [PATH_W-1:0]   eval_idx_reg;

    logic                fc_found_reg, fa_found_reg, mx_any_reg;
    logic [PATH_W-1:0]   fc_idx_reg, fa_idx_reg, mx_idx_reg;
    credit_t             fc_val_reg, fa_val_reg, mx_val_reg;

    logic [LEN_W-1:0]    len_reg;
    logic [PATH_W-1:0]   chosen_reg;
    credit_t             best_reg;
    rounds_t             k_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic                m_valid_reg;
    logic [PATH_W-1:0]   m_path_reg;

    logic                in_xfer;
    logic                rd_en;
    logic                pass_end;
    logic                track_clear;
    logic                sweep_mode;
    logic                div_start;
    logic                div_done;
    rounds_t             div_quot;
    rounds_t             div_dividend;

    credit_t             cur_val;
    logic signed [SUM_W-1:0]  refill_sum;
    credit_t             refill_val;
    credit_t             ev_val;
    logic signed [DIFF_W-1:0] charge_diff;
    credit_t             charge_val;

    logic                wr_en;
    logic [PATH_W-1:0]   wr_addr;
    credit_t             wr_data;

    // Effective configuration: out-of-range path counts, a zero quantum and a cursor past the paths in use are folded.
    always_comb begin
        if (pcount_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (int'(pcount_reg) > MAX_PATHS) begin
            n_eff = CNT_W'(MAX_PATHS);
        end else begin
            n_eff = CNT_W'(pcount_reg);
        end
        q_eff = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;
        c_eff = (CNT_W'(cursor_reg) < n_eff) ? cursor_reg : '0;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_path    = m_path_reg;
    assign in_xfer   = s_valid && s_ready;

    assign sweep_mode  = (state_reg == ST_SCAN) || (state_reg == ST_REFILL);
    assign rd_en       = sweep_mode && (issue_idx_reg < n_eff);
    assign pass_end    = eval_valid_reg && (CNT_W'(eval_idx_reg) == n_eff - CNT_W'(1));
    assign track_clear = (in_xfer && mode_reg != MODE_RR && mode_reg != MODE_RR_ALIAS)
                         || (state_reg == ST_MUL);

    // Evaluation stage: the word read last cycle, refilled when sweeping for a refill.
    always_comb begin
        cur_val    = rd_vld_reg ? rd_data_reg : '0;
        refill_sum = {{(SUM_W-CREDIT_BITS){cur_val[CREDIT_BITS-1]}}, cur_val}
                     + $signed({1'b0, prod_reg});
        refill_val = (refill_sum > SUM_MAX) ? CREDIT_MAX : refill_sum[CREDIT_BITS-1:0];
        ev_val     = (state_reg == ST_REFILL) ? refill_val : cur_val;

        charge_diff = {best_reg[CREDIT_BITS-1], best_reg}
                      - $signed({{(DIFF_W-LEN_W){1'b0}}, len_reg});
        charge_val  = (charge_diff < DIFF_MIN) ? CREDIT_MIN
                                               : charge_diff[CREDIT_BITS-1:0];
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = eval_idx_reg;
        wr_data = refill_val;
        if (state_reg == ST_CHARGE) begin
            wr_en   = 1'b1;
            wr_addr = chosen_reg;
            wr_data = charge_val;
        end else if (state_reg == ST_REFILL && eval_valid_reg) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (mode_reg == MODE_DRR || mode_reg == MODE_MAX) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (pass_end) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (mode_reg == MODE_DRR && fc_found_reg) begin
                    state_next = ST_CHARGE;
                end else if (mx_val_reg > 0) begin
                    state_next = (mode_reg == MODE_DRR) ? ST_MUL : ST_CHARGE;
                end else begin
                    state_next = ST_DIV;
                    div_start  = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_REFILL;
            ST_REFILL: begin
                if (pass_end) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:   state_next = ST_CHARGE;
            ST_CHARGE: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    assign div_dividend = rounds_t'(credit_t'(0) - mx_val_reg);

    cbps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (q_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= RST_MODE;
            quantum_reg    <= RST_QUANTUM;
            pcount_reg     <= RST_PATH_COUNT;
            cursor_reg     <= '0;
            entry_vld_reg  <= '0;
            issue_idx_reg  <= '0;
            eval_valid_reg <= 1'b0;
            fc_found_reg   <= 1'b0;
            fa_found_reg   <= 1'b0;
            mx_any_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            eval_valid_reg <= rd_en;

            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MODE:       mode_reg    <= cfg_data[MODE_W-1:0];
                    REG_QUANTUM:    quantum_reg <= cfg_data[QUANT_W-1:0];
                    REG_PATH_COUNT: pcount_reg  <= cfg_data[PCOUNT_W-1:0];
                    default: ;
                endcase
            end

            if (wr_en) begin
                entry_vld_reg[wr_addr] <= 1'b1;
            end

            if (track_clear) begin
                issue_idx_reg <= '0;
            end else if (rd_en) begin
                issue_idx_reg <= issue_idx_reg + CNT_W'(1);
            end

            if (in_xfer && (mode_reg == MODE_RR || mode_reg == MODE_RR_ALIAS)) begin
                cursor_reg <= (CNT_W'(c_eff) + CNT_W'(1) >= n_eff)
                              ? '0 : c_eff + PATH_W'(1);
            end else if (state_reg == ST_CHARGE) begin
                cursor_reg <= chosen_reg;
            end

            if (track_clear) begin
                fc_found_reg <= 1'b0;
                fa_found_reg <= 1'b0;
                mx_any_reg   <= 1'b0;
            end else if (eval_valid_reg) begin
                if (ev_val > 0 && !fa_found_reg) begin
                    fa_found_reg <= 1'b1;
                end
                if (ev_val > 0 && !fc_found_reg && eval_idx_reg >= c_eff) begin
                    fc_found_reg <= 1'b1;
                end
                mx_any_reg <= 1'b1;
            end

            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Credit memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            credit_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= credit_mem[issue_idx_reg[PATH_W-1:0]];
            rd_vld_reg  <= entry_vld_reg[issue_idx_reg[PATH_W-1:0]];
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        eval_idx_reg <= issue_idx_reg[PATH_W-1:0];

        if (!track_clear && eval_valid_reg) begin
            if (ev_val > 0 && !fa_found_reg) begin
                fa_idx_reg <= eval_idx_reg;
                fa_val_reg <= ev_val;
            end
            if (ev_val > 0 && !fc_found_reg && eval_idx_reg >= c_eff) begin
                fc_idx_reg <= eval_idx_reg;
                fc_val_reg <= ev_val;
            end
            // Strictly greater keeps the lowest index on a tie.
            if (!mx_any_reg || ev_val > mx_val_reg) begin
                mx_idx_reg <= eval_idx_reg;
                mx_val_reg <= ev_val;
            end
        end

        if (in_xfer) begin
            len_reg    <= s_packet_length;
            chosen_reg <= c_eff;
        end

        if (state_reg == ST_DECIDE) begin
            k_reg <= rounds_t'(1);
            if (mode_reg == MODE_DRR && fc_found_reg) begin
                chosen_reg <= fc_idx_reg;
                best_reg   <= fc_val_reg;
            end else begin
                chosen_reg <= mx_idx_reg;
                best_reg   <= mx_val_reg;
            end
        end

        if (state_reg == ST_DIV && div_done) begin
            k_reg <= div_quot + rounds_t'(1);
        end

        if (state_reg == ST_MUL) begin
            prod_reg <= PROD_W'(k_reg) * PROD_W'(q_eff);
        end

        if (state_reg == ST_PICK) begin
            if (mode_reg == MODE_DRR) begin
                chosen_reg <= fa_idx_reg;
                best_reg   <= fa_val_reg;
            end else begin
                chosen_reg <= mx_idx_reg;
                best_reg   <= mx_val_reg;
            end
        end

        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_path_reg <= chosen_reg;
        end
    end

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("credit memory written while idle");

    a_refill_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REFILL) |-> (prod_reg != '0))
        else $error("refill sweep with zero credit increment");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while one is in work");

    a_path_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (CNT_W'(chosen_reg) < n_eff))
        else $error("chosen path outside the paths in use");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

endmodule
